>>> sv/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types and constants of the pixel hit clusterer.
// ----------------------------------------------------------------------------
`default_nettype none
package phc_pkg;
  localparam int PixelCapacity = 64;
  localparam int FractionBits  = 6;
  localparam int AddrW         = $clog2(PixelCapacity);
  localparam int CountW        = $clog2(PixelCapacity + 1);
  localparam int MaxResults    = 64;
  localparam int ResW          = $clog2(MaxResults + 1);
  localparam int ColW          = 11;
  localparam int RowW          = 10;
  localparam int WeightW       = 4;
  localparam logic [WeightW-1:0] WeightMax = 4'd15;
  localparam int WsumW         = WeightW + CountW;
  localparam int CsumW         = ColW + WsumW;
  localparam int RsumW         = RowW + WsumW;
  localparam int CDivW         = CsumW + FractionBits;
  localparam int RDivW         = RsumW + FractionBits;

  typedef struct packed {
    logic [10:0] pixel_column;
    logic [9:0]  pixel_row;
    logic        hit_present;
    logic        event_end;
  } in_beat_t;

  typedef struct packed {
    logic        cluster_valid;
    logic [6:0]  pixel_count;
    logic [6:0]  column_extent;
    logic [6:0]  row_extent;
    logic [16:0] column_centroid;
    logic [15:0] row_centroid;
    logic        store_overflow;
    logic        last_of_event;
  } out_beat_t;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [CDivW-1:0] cnum;
    logic [RDivW-1:0] rnum;
    logic [WsumW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] cquo;
    logic [15:0] rquo;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> sv/phc_divider.sv
// ----------------------------------------------------------------------------
// phc_divider
// Restoring divider, one quotient bit per cycle, two numerators, shared
// denominator.
// ----------------------------------------------------------------------------
`default_nettype none
module phc_divider (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire phc_pkg::div_req_t req,
  output phc_pkg::div_rsp_t     rsp
);
  localparam int CW = phc_pkg::CDivW;
  localparam int RW = phc_pkg::RDivW;
  localparam int DW = phc_pkg::WsumW;
  localparam int StepW = $clog2(CW + 1);

  logic             busy_r, busy_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [CW-1:0]    cq_r, cq_nxt;
  logic [RW-1:0]    rq_r, rq_nxt;
  logic [DW:0]      crem_r, crem_nxt, rrem_r, rrem_nxt;
  logic [DW-1:0]    den_r;
  logic             done_r, done_nxt;
  logic [DW:0]      ctry, rtry;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    cq_nxt   = cq_r;
    rq_nxt   = rq_r;
    crem_nxt = crem_r;
    rrem_nxt = rrem_r;
    done_nxt = 1'b0;
    ctry = {crem_r[DW-1:0], cq_r[CW-1]};
    rtry = {rrem_r[DW-1:0], rq_r[RW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = StepW'(CW);
      cq_nxt   = req.cnum;
      rq_nxt   = req.rnum;
      crem_nxt = '0;
      rrem_nxt = '0;
    end else if (busy_r) begin
      if (ctry >= {1'b0, den_r}) begin
        crem_nxt = ctry - {1'b0, den_r};
        cq_nxt   = {cq_r[CW-2:0], 1'b1};
      end else begin
        crem_nxt = ctry;
        cq_nxt   = {cq_r[CW-2:0], 1'b0};
      end
      if (step_r <= StepW'(RW)) begin
        if (rtry >= {1'b0, den_r}) begin
          rrem_nxt = rtry - {1'b0, den_r};
          rq_nxt   = {rq_r[RW-2:0], 1'b1};
        end else begin
          rrem_nxt = rtry;
          rq_nxt   = {rq_r[RW-2:0], 1'b0};
        end
      end
      step_nxt = step_r - 1'b1;
      if (step_r == StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    cq_r   <= cq_nxt;
    rq_r   <= rq_nxt;
    crem_r <= crem_nxt;
    rrem_r <= rrem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.done = done_r;
  assign rsp.cquo = cq_r[16:0];
  assign rsp.rquo = rq_r[15:0];
endmodule
`default_nettype wire

>>> sv/pixel_hit_clusterer.sv
// ----------------------------------------------------------------------------
// pixel_hit_clusterer
// Groups one event's fired pixels into clusters, one result per cluster.
// ----------------------------------------------------------------------------
// Input: a beat is taken at a clock edge with start high and busy low.
// Beats without event_end store their pixel (if hit_present);
// busy stays low. A beat with event_end raises busy and starts clustering
// over the n stored pixels, held in a 64-entry pixel memory (one read per
// cycle, registered data) plus taken and member flag registers.
// Growth, per seed: passes over the n entries; a taken entry is skipped, an
// untaken one is read and probed against each entry until it faces a member.
// Passes repeat until one adds nothing.
// Weighting: each member is probed against every entry for its weight and
// summed; other entries are skipped. The divide is launched, the divider
// runs, then emit. The beat shows on out_valid the cycle after emit.
// Empty event: its beat shows the cycle after the closing beat is taken.
// After the last beat the clear state follows, then busy drops.
// Results: out_valid pulses for one cycle per beat; the receiver cannot
// stall. Reset: empties the store, gap_allowance returns to 1.
// cfg_we writes gap_allowance; the user must keep writes to idle, the block has no guard for it.
// ----------------------------------------------------------------------------
`default_nettype none
module pixel_hit_clusterer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire phc_pkg::in_beat_t    in_data,
  output logic                      out_valid,
  output phc_pkg::out_beat_t        out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_wdata
);
  localparam int AW = phc_pkg::AddrW;
  localparam int CNW = phc_pkg::CountW;
  localparam int N = phc_pkg::PixelCapacity;

  localparam logic [3:0] S_IDLE = 4'd0, S_SEED = 4'd1, S_GI = 4'd2,
    S_GP = 4'd3, S_GPW = 4'd4, S_WI = 4'd5, S_WP = 4'd6, S_WPW = 4'd7,
    S_ACC = 4'd8, S_DIV = 4'd9, S_EMIT = 4'd10, S_CLR = 4'd11, S_IW = 4'd12,
    S_WIW = 4'd13;

  logic [3:0] st_r;
  logic [1:0] gap_r;
  logic [CNW-1:0] cnt_r;
  logic ovf_r;
  logic [N-1:0] taken_r, incl_r;

  logic [phc_pkg::ColW-1:0] mem_col [N];
  logic [phc_pkg::RowW-1:0] mem_row [N];
  logic [phc_pkg::ColW-1:0] rd_col_r;
  logic [phc_pkg::RowW-1:0] rd_row_r;
  logic rd_en;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] seed_r, i_r, p_r;
  logic grow_r;
  logic [phc_pkg::ColW-1:0] ic_r;
  logic [phc_pkg::RowW-1:0] ir_r;
  logic [phc_pkg::WeightW-1:0] w_r;
  logic [CNW-1:0] size_r;
  logic [phc_pkg::WsumW-1:0] wsum_r;
  logic [phc_pkg::CsumW-1:0] csum_r;
  logic [phc_pkg::RsumW-1:0] rsum_r;
  logic [phc_pkg::ColW-1:0] cmin_r, cmax_r;
  logic [phc_pkg::RowW-1:0] rmin_r, rmax_r;
  logic [phc_pkg::ResW-1:0] nres_r;
  phc_pkg::out_beat_t od_r;
  logic ov_r;
  logic last_seed;
  phc_pkg::div_req_t dreq;
  phc_pkg::div_rsp_t drsp;

  wire acc = start && !busy;
  wire [AW-1:0] nlast = AW'(cnt_r - 1'b1);
  wire [phc_pkg::ColW-1:0] dc = (rd_col_r > ic_r) ? rd_col_r - ic_r : ic_r - rd_col_r;
  wire [phc_pkg::RowW-1:0] dr = (rd_row_r > ir_r) ? rd_row_r - ir_r : ir_r - rd_row_r;
  wire facing = (dc == '0 && dr <= {8'd0, gap_r}) || (dr == '0 && dc <= {9'd0, gap_r});
  wire near = dc <= 11'd1 && dr <= 10'd1;
  wire joined = incl_r[p_r] && facing;
  wire empty_end = acc && in_data.event_end && !in_data.hit_present && cnt_r == '0;

  assign busy = st_r != S_IDLE;

  phc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // memory read address
  always_comb begin
    rd_en = 1'b1;
    rd_addr = p_r;
    unique case (st_r)
      S_GI, S_WI: rd_addr = i_r;
      default: rd_addr = p_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.hit_present && cnt_r < CNW'(N)) begin
      mem_col[cnt_r[AW-1:0]] <= in_data.pixel_column;
      mem_row[cnt_r[AW-1:0]] <= in_data.pixel_row;
    end
    if (rd_en) begin
      rd_col_r <= mem_col[rd_addr];
      rd_row_r <= mem_row[rd_addr];
    end
  end

  always_comb begin
    last_seed = 1'b1;
    for (int k = 0; k < N; k++)
      if (k > int'(seed_r) && k < int'(cnt_r) && !taken_r[k]) last_seed = 1'b0;
  end

  always_comb begin
    dreq.start = st_r == S_ACC && i_r == nlast && p_r == AW'(1);
    dreq.cnum = {csum_r, {phc_pkg::FractionBits{1'b0}}};
    dreq.rnum = {rsum_r, {phc_pkg::FractionBits{1'b0}}};
    dreq.den = wsum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      gap_r <= 2'd1;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      taken_r <= '0;
      ov_r <= 1'b0;
    end else begin
      ov_r <= (st_r == S_EMIT) || (st_r == S_IDLE && empty_end);
      if (cfg_we) gap_r <= cfg_wdata;
      unique case (st_r)
        S_IDLE: if (acc) begin
          if (in_data.hit_present) begin
            if (cnt_r < CNW'(N)) cnt_r <= cnt_r + 1'b1;
            else ovf_r <= 1'b1;
          end
          if (in_data.event_end) begin
            seed_r <= '0;
            nres_r <= '0;
            if (in_data.hit_present || cnt_r != '0) st_r <= S_SEED;
            else begin
              od_r <= {1'b0, 7'd0, 7'd0, 7'd0, 17'd0, 16'd0, ovf_r, 1'b1};
              st_r <= S_CLR;
            end
          end
        end
        S_SEED: begin
          if (taken_r[seed_r]) begin
            seed_r <= seed_r + 1'b1;
          end else begin
            taken_r[seed_r] <= 1'b1;
            incl_r <= {{(N-1){1'b0}}, 1'b1} << seed_r;
            i_r <= '0;
            grow_r <= 1'b0;
            st_r <= S_GI;
          end
        end
        S_GI: begin
          if (taken_r[i_r]) begin
            if (i_r == nlast) begin
              if (grow_r) begin i_r <= '0; grow_r <= 1'b0; end
              else begin i_r <= '0; p_r <= '0; st_r <= S_WI; end
            end else i_r <= i_r + 1'b1;
          end else st_r <= S_IW;
        end
        S_IW: begin
          ic_r <= rd_col_r; ir_r <= rd_row_r; p_r <= '0; st_r <= S_GP;
        end
        S_GP: st_r <= S_GPW;
        S_GPW: begin
          if (joined) begin
            taken_r[i_r] <= 1'b1;
            incl_r[i_r] <= 1'b1;
          end
          if (p_r == nlast || joined) begin
            if (i_r == nlast) begin
              i_r <= '0;
              if (grow_r || joined) begin
                grow_r <= 1'b0; st_r <= S_GI;
              end else st_r <= S_WI;
            end else begin
              i_r <= i_r + 1'b1;
              st_r <= S_GI;
              if (joined) grow_r <= 1'b1;
            end
          end else begin p_r <= p_r + 1'b1; st_r <= S_GP; end
        end
        S_WI: begin
          if (i_r == '0) begin
            size_r <= '0; wsum_r <= '0; csum_r <= '0; rsum_r <= '0;
            cmin_r <= '1; cmax_r <= '0; rmin_r <= '1; rmax_r <= '0;
          end
          if (!incl_r[i_r]) begin
            if (i_r == nlast) begin p_r <= AW'(1); st_r <= S_ACC; end
            else i_r <= i_r + 1'b1;
          end else st_r <= S_WIW;
        end
        S_WIW: begin
          ic_r <= rd_col_r; ir_r <= rd_row_r; p_r <= '0; w_r <= 4'd1;
          st_r <= S_WP;
        end
        S_WP: st_r <= S_WPW;
        S_WPW: begin
          if (p_r != i_r && incl_r[p_r] && near && w_r != phc_pkg::WeightMax)
            w_r <= w_r + 1'b1;
          if (p_r == nlast) begin
            st_r <= S_ACC;
            p_r <= '0;
          end else begin p_r <= p_r + 1'b1; st_r <= S_WP; end
        end
        S_ACC: begin
          if (p_r == '0) begin
            size_r <= size_r + 1'b1;
            wsum_r <= wsum_r + phc_pkg::WsumW'(w_r);
            csum_r <= csum_r + phc_pkg::CsumW'(w_r) * phc_pkg::CsumW'(ic_r);
            rsum_r <= rsum_r + phc_pkg::RsumW'(w_r) * phc_pkg::RsumW'(ir_r);
            if (ic_r < cmin_r) cmin_r <= ic_r;
            if (ic_r > cmax_r) cmax_r <= ic_r;
            if (ir_r < rmin_r) rmin_r <= ir_r;
            if (ir_r > rmax_r) rmax_r <= ir_r;
            if (i_r == nlast) p_r <= AW'(1);
            else begin i_r <= i_r + 1'b1; st_r <= S_WI; end
          end else st_r <= S_DIV;
        end
        S_DIV: if (drsp.done) st_r <= S_EMIT;
        S_EMIT: begin
          od_r.cluster_valid <= 1'b1;
          od_r.pixel_count <= (size_r > 7'd127) ? 7'd127 : 7'(size_r);
          od_r.column_extent <= ((cmax_r - cmin_r) >= 11'd127) ? 7'd127
                                : 7'(cmax_r - cmin_r + 1'b1);
          od_r.row_extent <= ((rmax_r - rmin_r) >= 10'd127) ? 7'd127
                             : 7'(rmax_r - rmin_r + 1'b1);
          od_r.column_centroid <= drsp.cquo;
          od_r.row_centroid <= drsp.rquo;
          od_r.store_overflow <= ovf_r;
          od_r.last_of_event <= last_seed ||
            nres_r == phc_pkg::ResW'(phc_pkg::MaxResults - 1) || seed_r == nlast;
          nres_r <= nres_r + 1'b1;
          if (last_seed || seed_r == nlast ||
              nres_r == phc_pkg::ResW'(phc_pkg::MaxResults - 1)) st_r <= S_CLR;
          else begin seed_r <= seed_r + 1'b1; st_r <= S_SEED; end
        end
        S_CLR: begin
          taken_r <= '0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_data = od_r;
endmodule
`default_nettype wire

>>> sv/phc_checker.sv
// ----------------------------------------------------------------------------
// phc_checker
// Port-level checks of the pixel hit clusterer.
// ----------------------------------------------------------------------------
`default_nettype none
module phc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire phc_pkg::out_beat_t out_data
);
  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");
  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start)) else $error("stray result");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_event |=> !out_valid)
    else $error("result after last");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cluster_valid |-> out_data.last_of_event)
    else $error("empty result not last");
endmodule
bind pixel_hit_clusterer phc_checker u_phc_checker (.*);
`default_nettype wire
